// ----- rtl/tgr_pkg.sv -----
`timescale 1ns / 1ps

package tgr_pkg;

    typedef enum logic [1:0] {
        OP_TEXT    = 2'd0,
        OP_FONT    = 2'd1,
        OP_PALETTE = 2'd2,
        OP_UNUSED  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CMD_DRAW = 2'd0,
        CMD_FONT = 2'd1,
        CMD_PAL  = 2'd2
    } cmd_kind_t;

    localparam logic [1:0] CFG_HIGHLIGHT = 2'd0;
    localparam logic [1:0] CFG_DEF_FG    = 2'd1;
    localparam logic [1:0] CFG_DEF_BG    = 2'd2;

    localparam logic       HL_RESET     = 1'b1;
    localparam logic [3:0] DEF_FG_RESET = 4'd0;
    localparam logic [3:0] DEF_BG_RESET = 4'd9;

    localparam logic [7:0] ESC_CHAR   = 8'h1B;
    localparam logic [7:0] TAB_CHAR   = 8'h09;
    localparam logic [7:0] NL_CHAR    = 8'h0A;
    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] CUR_MAX    = 8'hFF;

    localparam int GLYPH_W    = 8;
    localparam int FONT_ROW_W = 4;
    localparam int FONT_DEPTH = 4096;
    localparam int CNT_W      = 3;
    localparam int X_W        = 12;
    localparam int Y_W        = 13;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [7:0]         char_code;
        logic [11:0]        addr;
        logic [31:0]        data;
        logic [7:0]         col;
        logic [7:0]         row;
        logic [3:0]         fg_idx;
        logic [3:0]         bg_idx;
        logic [CNT_W-1:0]   count;
    } cmd_t;

    typedef struct packed {
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
        logic [7:0]     glyph;
        logic [31:0]    fg;
        logic [31:0]    bg;
        logic           last;
    } pix_t;

endpackage

// ----- rtl/tgr_front.sv -----
`timescale 1ns / 1ps

module tgr_front #(
    parameter int TAB_WIDTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_addr,
    input  logic [3:0]        cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  tgr_pkg::op_t      in_op,
    input  logic [7:0]        in_byte,
    input  logic [11:0]       in_addr,
    input  logic [31:0]       in_data,
    output logic              push,
    output tgr_pkg::cmd_t     cmd,
    input  logic              q_ready
);

    typedef enum logic [3:0] {
        ESC_NONE = 4'b0001,
        ESC_FG   = 4'b0010,
        ESC_BG   = 4'b0100,
        ESC_PAD  = 4'b1000
    } esc_t;

    esc_t       esc_reg, esc_next;
    logic       hl_reg;
    logic [3:0] def_fg_reg, def_bg_reg;
    logic [7:0] col_reg, col_next;
    logic [7:0] row_reg, row_next;
    logic [3:0] pend_reg, pend_next;
    logic [3:0] fg_reg, fg_next;
    logic [3:0] bg_reg, bg_next;

    logic                      accept;
    logic                      is_tab;
    logic [tgr_pkg::CNT_W-1:0] cnt;
    logic [8:0]                col_sum;

    assign in_ready = q_ready;
    assign accept   = in_valid && q_ready;
    assign is_tab   = (in_byte == tgr_pkg::TAB_CHAR);
    assign cnt      = is_tab ? tgr_pkg::CNT_W'(TAB_WIDTH) : tgr_pkg::CNT_W'(1);
    assign col_sum  = {1'b0, col_reg} + 9'(cnt);

    always_comb
    begin
        esc_next  = esc_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        pend_next = pend_reg;
        fg_next   = fg_reg;
        bg_next   = bg_reg;
        push      = 1'b0;

        cmd.kind      = tgr_pkg::CMD_DRAW;
        cmd.char_code = is_tab ? tgr_pkg::SPACE_CHAR : in_byte;
        cmd.addr      = in_addr;
        cmd.data      = in_data;
        cmd.col       = col_reg;
        cmd.row       = row_reg;
        cmd.fg_idx    = fg_reg;
        cmd.bg_idx    = bg_reg;
        cmd.count     = cnt;

        if (accept)
        begin
            unique case (in_op)
                tgr_pkg::OP_FONT:
                begin
                    push     = 1'b1;
                    cmd.kind = tgr_pkg::CMD_FONT;
                end
                tgr_pkg::OP_PALETTE:
                begin
                    push     = 1'b1;
                    cmd.kind = tgr_pkg::CMD_PAL;
                end
                tgr_pkg::OP_TEXT:
                begin
                    unique case (esc_reg)
                        ESC_FG:
                        begin
                            pend_next = in_byte[3:0];
                            esc_next  = ESC_BG;
                        end
                        ESC_BG:
                        begin
                            if (hl_reg)
                            begin
                                fg_next = pend_reg;
                                bg_next = in_byte[3:0];
                            end
                            esc_next = ESC_PAD;
                        end
                        ESC_PAD:
                        begin
                            esc_next = ESC_NONE;
                        end
                        default:
                        begin
                            if (in_byte == tgr_pkg::ESC_CHAR)
                            begin
                                esc_next = ESC_FG;
                            end
                            else if (in_byte == tgr_pkg::NL_CHAR)
                            begin
                                if (row_reg != tgr_pkg::CUR_MAX)
                                begin
                                    row_next = row_reg + 8'd1;
                                end
                                col_next = '0;
                                fg_next  = def_fg_reg;
                                bg_next  = def_bg_reg;
                            end
                            else
                            begin
                                push     = 1'b1;
                                col_next = (col_sum > 9'(tgr_pkg::CUR_MAX)) ?
                                           tgr_pkg::CUR_MAX : col_sum[7:0];
                            end
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg  <= ESC_NONE;
            col_reg  <= '0;
            row_reg  <= '0;
            pend_reg <= '0;
            fg_reg   <= tgr_pkg::DEF_FG_RESET;
            bg_reg   <= tgr_pkg::DEF_BG_RESET;
        end
        else
        begin
            esc_reg  <= esc_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
            pend_reg <= pend_next;
            fg_reg   <= fg_next;
            bg_reg   <= bg_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hl_reg     <= tgr_pkg::HL_RESET;
            def_fg_reg <= tgr_pkg::DEF_FG_RESET;
            def_bg_reg <= tgr_pkg::DEF_BG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                tgr_pkg::CFG_HIGHLIGHT: hl_reg     <= cfg_wdata[0];
                tgr_pkg::CFG_DEF_FG:    def_fg_reg <= cfg_wdata;
                tgr_pkg::CFG_DEF_BG:    def_bg_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

endmodule

// ----- rtl/tgr_queue.sv -----
`timescale 1ns / 1ps

module tgr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tgr_pkg::cmd_t wdata,
    output logic          ready,
    output logic          valid,
    input  logic          pop,
    output tgr_pkg::cmd_t rdata
);

    localparam int DEPTH = 2;
    localparam int AW    = $clog2(DEPTH);

    tgr_pkg::cmd_t   mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]     cnt_reg;

    assign ready = (cnt_reg != (AW+1)'(DEPTH));
    assign valid = (cnt_reg != '0);
    assign rdata = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ready)
        else $error("command pushed into full queue");

endmodule

// ----- rtl/tgr_back.sv -----
`timescale 1ns / 1ps

module tgr_back #(
    parameter int GLYPH_H       = 16,
    parameter int MARGIN_PX     = 10,
    parameter int LINE_GAP      = 1,
    parameter int PALETTE_DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_pop,
    input  tgr_pkg::cmd_t cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output tgr_pkg::pix_t out_pix
);

    localparam int ROW_W      = $clog2(GLYPH_H);
    localparam int LINE_PITCH = GLYPH_H + LINE_GAP;
    localparam int PAL_AW     = $clog2(PALETTE_DEPTH);
    localparam int OUT_DEPTH  = 4;
    localparam int OUT_AW     = $clog2(OUT_DEPTH);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GLYPH_H - 1);
    localparam logic [4:0] PAL_LIMIT = 5'(PALETTE_DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_PAL_FG = 4'b0010,
        ST_PAL_BG = 4'b0100,
        ST_ROWS   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [7:0]  font_mem [tgr_pkg::FONT_DEPTH];
    logic [31:0] pal_mem  [PALETTE_DEPTH];

    logic [7:0]                char_reg, char_next;
    logic [7:0]                col_reg, col_next;
    logic [tgr_pkg::CNT_W-1:0] glyphs_reg, glyphs_next;
    logic [ROW_W-1:0]          row_cnt_reg, row_cnt_next;
    logic [tgr_pkg::Y_W-1:0]   base_y_reg, base_y_next;
    logic [3:0]                bg_sel_reg, bg_sel_next;
    logic                      fg_zero_reg, fg_zero_next;
    logic                      bg_zero_reg, bg_zero_next;
    logic [31:0]               fg_color_reg, fg_color_next;
    logic [31:0]               bg_color_reg, bg_color_next;
    logic [31:0]               pal_rd_reg;
    logic [7:0]                font_rd_reg;

    logic                      s1_valid_reg;
    logic [tgr_pkg::X_W-1:0]   s1_x_reg;
    logic [tgr_pkg::Y_W-1:0]   s1_y_reg;
    logic                      s1_last_reg;

    tgr_pkg::pix_t             ofifo [OUT_DEPTH];
    logic [OUT_AW-1:0]         owr_ptr_reg, ord_ptr_reg;
    logic [OUT_AW:0]           ocnt_reg;

    logic                      font_we, pal_we;
    logic [PAL_AW-1:0]         pal_raddr;
    logic                      issue, row_last;
    logic [tgr_pkg::X_W-1:0]   pix_x;
    logic [tgr_pkg::Y_W-1:0]   pix_y;
    logic [11:0]               font_raddr;
    logic                      opop;
    logic [OUT_AW:0]           occupied;

    assign opop      = out_valid && out_ready;
    assign out_valid = (ocnt_reg != '0);
    assign out_pix   = ofifo[ord_ptr_reg];
    assign occupied  = ocnt_reg + (OUT_AW+1)'(s1_valid_reg);

    assign issue      = (state_reg == ST_ROWS) && (occupied < (OUT_AW+1)'(OUT_DEPTH));
    assign row_last   = (row_cnt_reg == LAST_ROW);
    assign pix_x      = tgr_pkg::X_W'(MARGIN_PX)
                        + tgr_pkg::X_W'(col_reg) * tgr_pkg::X_W'(tgr_pkg::GLYPH_W);
    assign pix_y      = base_y_reg + tgr_pkg::Y_W'(row_cnt_reg);
    assign font_raddr = {char_reg, tgr_pkg::FONT_ROW_W'(row_cnt_reg)};

    always_comb
    begin
        state_next    = state_reg;
        char_next     = char_reg;
        col_next      = col_reg;
        glyphs_next   = glyphs_reg;
        row_cnt_next  = row_cnt_reg;
        base_y_next   = base_y_reg;
        bg_sel_next   = bg_sel_reg;
        fg_zero_next  = fg_zero_reg;
        bg_zero_next  = bg_zero_reg;
        fg_color_next = fg_color_reg;
        bg_color_next = bg_color_reg;
        q_pop         = 1'b0;
        font_we       = 1'b0;
        pal_we        = 1'b0;
        pal_raddr     = ({1'b0, bg_sel_reg} < PAL_LIMIT) ? bg_sel_reg[PAL_AW-1:0] : '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                pal_raddr = ({1'b0, cmd.fg_idx} < PAL_LIMIT) ? cmd.fg_idx[PAL_AW-1:0] : '0;
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    unique case (cmd.kind)
                        tgr_pkg::CMD_FONT:
                        begin
                            font_we = 1'b1;
                        end
                        tgr_pkg::CMD_PAL:
                        begin
                            pal_we = ({1'b0, cmd.addr[3:0]} < PAL_LIMIT);
                        end
                        default:
                        begin
                            char_next    = cmd.char_code;
                            col_next     = cmd.col;
                            glyphs_next  = cmd.count;
                            bg_sel_next  = cmd.bg_idx;
                            fg_zero_next = ({1'b0, cmd.fg_idx} >= PAL_LIMIT);
                            bg_zero_next = ({1'b0, cmd.bg_idx} >= PAL_LIMIT);
                            base_y_next  = tgr_pkg::Y_W'(MARGIN_PX)
                                           + tgr_pkg::Y_W'(cmd.row)
                                           * tgr_pkg::Y_W'(LINE_PITCH);
                            state_next   = ST_PAL_FG;
                        end
                    endcase
                end
            end
            ST_PAL_FG:
            begin
                fg_color_next = fg_zero_reg ? '0 : pal_rd_reg;
                state_next    = ST_PAL_BG;
            end
            ST_PAL_BG:
            begin
                bg_color_next = bg_zero_reg ? '0 : pal_rd_reg;
                row_cnt_next  = '0;
                state_next    = ST_ROWS;
            end
            default:
            begin
                if (issue)
                begin
                    if (row_last)
                    begin
                        row_cnt_next = '0;
                        if (glyphs_reg == tgr_pkg::CNT_W'(1))
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            glyphs_next = glyphs_reg - tgr_pkg::CNT_W'(1);
                            if (col_reg != tgr_pkg::CUR_MAX)
                            begin
                                col_next = col_reg + 8'd1;
                            end
                        end
                    end
                    else
                    begin
                        row_cnt_next = row_cnt_reg + ROW_W'(1);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (font_we)
        begin
            font_mem[cmd.addr] <= cmd.data[7:0];
        end
        if (issue)
        begin
            font_rd_reg <= font_mem[font_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pal_we)
        begin
            pal_mem[cmd.addr[PAL_AW-1:0]] <= cmd.data;
        end
        pal_rd_reg <= pal_mem[pal_raddr];
    end

    always_ff @(posedge clk)
    begin
        char_reg      <= char_next;
        col_reg       <= col_next;
        glyphs_reg    <= glyphs_next;
        row_cnt_reg   <= row_cnt_next;
        base_y_reg    <= base_y_next;
        bg_sel_reg    <= bg_sel_next;
        fg_zero_reg   <= fg_zero_next;
        bg_zero_reg   <= bg_zero_next;
        fg_color_reg  <= fg_color_next;
        bg_color_reg  <= bg_color_next;
        s1_x_reg      <= pix_x;
        s1_y_reg      <= pix_y;
        s1_last_reg   <= row_last && (glyphs_reg == tgr_pkg::CNT_W'(1));
        if (s1_valid_reg)
        begin
            ofifo[owr_ptr_reg] <= '{x:     s1_x_reg,
                                    y:     s1_y_reg,
                                    glyph: font_rd_reg,
                                    fg:    fg_color_reg,
                                    bg:    bg_color_reg,
                                    last:  s1_last_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            s1_valid_reg <= 1'b0;
            owr_ptr_reg  <= '0;
            ord_ptr_reg  <= '0;
            ocnt_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= issue;
            if (s1_valid_reg)
            begin
                owr_ptr_reg <= owr_ptr_reg + OUT_AW'(1);
            end
            if (opop)
            begin
                ord_ptr_reg <= ord_ptr_reg + OUT_AW'(1);
            end
            ocnt_reg <= ocnt_reg + (OUT_AW+1)'(s1_valid_reg) - (OUT_AW+1)'(opop);
        end
    end

    a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
        occupied <= (OUT_AW+1)'(OUT_DEPTH))
        else $error("row in flight without room in output buffer");

    a_glyphs_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROWS) |-> (glyphs_reg != '0))
        else $error("row sequencer running with no glyph left");

endmodule

// ----- rtl/text_glyph_rasterizer.sv -----
`timescale 1ns / 1ps

// text glyph rasterizer
// s channel: one item per input; tuser is the operation (0 text byte,
//   1 font row write, 2 palette entry write, 3 ignored)
// m channel: one item per glyph row drawn; tlast marks the final row of an input
// cfg port: 0 highlight enable, 1 default fg index, 2 default bg index
// a printable byte gives GLYPH_H rows and a tab TAB_WIDTH * GLYPH_H rows;
//   escape bytes, newlines and table writes give none
// back end handles each table write as it pops it; for a glyph it reads the
//   fg then bg palette entry, then does one font memory read per row, and a
//   tab repeats GLYPH_H rows per extra space
// each row passes the font memory read and s1 registers into the output buffer
// a 2-entry command queue lets input items be taken while rows are drawn;
//   a 4-entry output buffer absorbs m_tready stalls, and the row sequencer
//   pauses when it is full
// reset clears cursor and escape state and sets fg/bg selects to 0 and 9; font and palette
//   contents are undefined and must be loaded before use

module text_glyph_rasterizer #(
    parameter int GLYPH_H       = 16,
    parameter int MARGIN_PX     = 10,
    parameter int LINE_GAP      = 1,
    parameter int TAB_WIDTH     = 4,
    parameter int PALETTE_DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_addr,
    input  logic [3:0]    cfg_wdata,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [55:0]   s_tdata,   // byte_value, table_addr, table_data
    input  logic [1:0]    s_tuser,   // operation
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [103:0]  m_tdata,   // pixel_x, pixel_y, glyph_bits, fg_color, bg_color
    output logic          m_tlast
);

    logic          push, q_ready, q_valid, q_pop;
    tgr_pkg::cmd_t push_cmd, head_cmd;
    tgr_pkg::pix_t pix;

    tgr_front #(
        .TAB_WIDTH (TAB_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (tgr_pkg::op_t'(s_tuser)),
        .in_byte   (s_tdata[7:0]),
        .in_addr   (s_tdata[19:8]),
        .in_data   (s_tdata[51:20]),
        .push      (push),
        .cmd       (push_cmd),
        .q_ready   (q_ready)
    );

    tgr_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_cmd),
        .ready (q_ready),
        .valid (q_valid),
        .pop   (q_pop),
        .rdata (head_cmd)
    );

    tgr_back #(
        .GLYPH_H       (GLYPH_H),
        .MARGIN_PX     (MARGIN_PX),
        .LINE_GAP      (LINE_GAP),
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .cmd       (head_cmd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pix   (pix)
    );

    assign m_tdata = {7'b0, pix.bg, pix.fg, pix.glyph, pix.y, pix.x};
    assign m_tlast = pix.last;

endmodule
